### hdl/sacl_pkg.sv
// Shared types, constants and helpers for the set-associative LRU tag store.
package sacl_pkg;

    // Age of a line within its set; 0 is the most recent
    typedef logic [2:0] rank_t;

    localparam rank_t AGE_MAX = 3'd7;

    // Configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SET_INDEX_BITS = 1'b0;
    localparam cfg_idx_t CFG_WAYS_IN_USE    = 1'b1;

    // Configuration register width
    localparam int CFG_W = 4;

    // Age a line by one, saturating at the top age
    function automatic rank_t age_up(input rank_t a);
        age_up = (a < AGE_MAX) ? rank_t'(a + 3'd1) : AGE_MAX;
    endfunction

endpackage

### hdl/set_assoc_cache_lru_lookup_unit.sv
// Set-associative cache tag store with true LRU replacement, one lookup per request.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    address
//  out       output     out_valid / out_ready  hit, way_used
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  A request first reads the set row from the tag and meta memories, then
//  resolves hit/victim, writes the row back and loads the result.
//  After reset a clearing pass writes every meta row, one row a cycle:
//  2^floor(log2(MAX_SET_COUNT)) rows (1024 at the defaults); in_ready stays low.
//  A result waiting on out_ready does not block the next request from entering;
//  that request holds in its resolve step until the output register is free.
module set_assoc_cache_lru_lookup_unit #(
    parameter int MAX_WAY_COUNT = 8,
    parameter int MAX_SET_COUNT = 1024,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ADDRESS_WIDTH-1:0] address,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [2:0]               way_used,
    input  logic                     cfg_we,
    input  sacl_pkg::cfg_idx_t       cfg_index,
    input  logic [sacl_pkg::CFG_W-1:0] cfg_data
);

    import sacl_pkg::*;

    localparam int MAX_INDEX_BITS = $clog2(MAX_SET_COUNT + 1) - 1;
    localparam int SET_COUNT      = 1 << MAX_INDEX_BITS;
    localparam int SET_W          = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W          = (MAX_WAY_COUNT > 1) ? $clog2(MAX_WAY_COUNT) : 1;
    localparam int PICK_W         = (WAY_W > 3) ? WAY_W : 3;
    localparam int CNT_W          = $clog2(MAX_WAY_COUNT + 1);
    localparam int WCMP_W         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int META_LANE      = 4;
    localparam int META_W         = MAX_WAY_COUNT * META_LANE;
    localparam int TAG_ROW_W      = MAX_WAY_COUNT * ADDRESS_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CALC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         index_bits_reg;
    logic [CFG_W-1:0]         ways_cfg_reg;
    logic [SET_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]         set_reg;
    logic [ADDRESS_WIDTH-1:0] tag_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     hit_reg;
    logic [2:0]               way_reg;

    // Memory ports
    logic                 meta_we, meta_re;
    logic [SET_W-1:0]     meta_waddr;
    logic [META_W-1:0]    meta_wdata, meta_rdata;
    logic                 tag_we;
    logic [TAG_ROW_W-1:0] tag_wdata, tag_rdata;

    // Effective configuration
    logic [CFG_W-1:0]         eff_bits;
    logic [CNT_W-1:0]         ways_eff;
    logic [SET_W-1:0]         set_mask;
    logic [SET_W-1:0]         in_set;
    logic [ADDRESS_WIDTH-1:0] in_tag;

    logic accept, finish;

    // Resolve results
    logic                 hit_c;
    logic [PICK_W-1:0]    pick_c;
    logic [META_W-1:0]    meta_new;
    logic [TAG_ROW_W-1:0] tag_new;

    assign accept = in_valid && in_ready;
    assign finish = (state_reg == S_CALC) && (!out_valid_reg || out_ready);

    // Clamp the configuration to what the storage supports
    always_comb
    begin
        if (index_bits_reg > CFG_W'(MAX_INDEX_BITS))
        begin
            eff_bits = CFG_W'(MAX_INDEX_BITS);
        end
        else
        begin
            eff_bits = index_bits_reg;
        end
        if (ways_cfg_reg == '0)
        begin
            ways_eff = CNT_W'(1);
        end
        else if (WCMP_W'(ways_cfg_reg) > WCMP_W'(MAX_WAY_COUNT))
        begin
            ways_eff = CNT_W'(MAX_WAY_COUNT);
        end
        else
        begin
            ways_eff = CNT_W'(ways_cfg_reg);
        end
    end

    // Split the incoming address into set and tag
    assign set_mask = ~({SET_W{1'b1}} << eff_bits);
    assign in_set   = address[SET_W-1:0] & set_mask;
    assign in_tag   = address >> eff_bits;

    // Resolve hit or victim and build the updated rows
    always_comb
    begin
        logic                     found;
        logic                     have_free;
        logic [MAX_WAY_COUNT-1:0] act;
        logic [MAX_WAY_COUNT-1:0] vld;
        rank_t                    rk [MAX_WAY_COUNT];
        logic [ADDRESS_WIDTH-1:0] tg [MAX_WAY_COUNT];
        rank_t                    ref_age;
        rank_t                    nr;
        logic                     nv;

        found     = 1'b0;
        have_free = 1'b0;
        pick_c    = '0;
        ref_age   = '0;
        for (int w = 0; w < MAX_WAY_COUNT; w++)
        begin
            act[w] = CNT_W'(w) < ways_eff;
            vld[w] = meta_rdata[w*META_LANE + 3];
            rk[w]  = meta_rdata[w*META_LANE +: 3];
            tg[w]  = tag_rdata[w*ADDRESS_WIDTH +: ADDRESS_WIDTH];
        end

        // Lowest-numbered matching way
        for (int w = 0; w < MAX_WAY_COUNT; w++)
        begin
            if (!found && act[w] && vld[w] && (tg[w] == tag_reg))
            begin
                pick_c = PICK_W'(w);
                found  = 1'b1;
            end
        end

        if (found)
        begin
            ref_age = rk[pick_c[WAY_W-1:0]];
        end
        else
        begin
            // Lowest-numbered free way
            for (int w = 0; w < MAX_WAY_COUNT; w++)
            begin
                if (!have_free && act[w] && !vld[w])
                begin
                    pick_c    = PICK_W'(w);
                    have_free = 1'b1;
                end
            end
            // Otherwise the oldest way, lowest-numbered on ties
            if (!have_free)
            begin
                pick_c  = '0;
                ref_age = rk[0];
                for (int w = 1; w < MAX_WAY_COUNT; w++)
                begin
                    if (act[w] && (rk[w] > ref_age))
                    begin
                        pick_c  = PICK_W'(w);
                        ref_age = rk[w];
                    end
                end
            end
        end
        hit_c = found;

        // Age the ways used more recently than the picked one
        for (int w = 0; w < MAX_WAY_COUNT; w++)
        begin
            nr = rk[w];
            nv = vld[w];
            tag_new[w*ADDRESS_WIDTH +: ADDRESS_WIDTH] = tg[w];
            if (PICK_W'(w) == pick_c)
            begin
                nr = '0;
                nv = 1'b1;
                tag_new[w*ADDRESS_WIDTH +: ADDRESS_WIDTH] = tag_reg;
            end
            else if (act[w] && vld[w] && ((!found && have_free) || (rk[w] < ref_age)))
            begin
                nr = age_up(rk[w]);
            end
            meta_new[w*META_LANE +: META_LANE] = {nv, nr};
        end
    end

    // Drive memory ports: clearing pass, or write-back of the resolved row
    always_comb
    begin
        meta_re    = accept;
        meta_we    = 1'b0;
        meta_waddr = set_reg;
        meta_wdata = meta_new;
        tag_we     = finish;
        tag_wdata  = tag_new;
        if (state_reg == S_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_reg;
            meta_wdata = '0;
        end
        else if (finish)
        begin
            meta_we = 1'b1;
        end
    end

    sacl_ram #(
        .WIDTH (META_W),
        .DEPTH (SET_COUNT)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (in_set),
        .rdata (meta_rdata)
    );

    sacl_ram #(
        .WIDTH (TAG_ROW_W),
        .DEPTH (SET_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (set_reg),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (in_set),
        .rdata (tag_rdata)
    );

    // Sequence clear, idle and resolve steps
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(SET_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold the result until taken, load a new one when resolved
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            index_bits_reg <= '0;
            ways_cfg_reg   <= CFG_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SET_INDEX_BITS: index_bits_reg <= cfg_data;
                    CFG_WAYS_IN_USE:    ways_cfg_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        if (finish)
        begin
            hit_reg <= hit_c;
            way_reg <= pick_c[2:0];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign way_used  = way_reg;

    // A set row is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(meta_we && meta_re))
        else $error("meta row written and read in the same cycle");

    // The chosen way lies among the ways in use
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (CNT_W'(pick_c) < ways_eff))
        else $error("picked way outside the ways in use");

    // A resolved request shows up on the output in the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid && (hit == $past(hit_c)))
        else $error("resolved result not presented");

    // No request enters before the clearing pass is done
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !$past(accept))
        else $error("request accepted during clearing pass");

endmodule

### hdl/sacl_ram.sv
// Generic simple dual-port RAM with registered read.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
